// ===== sv/csv_record_tokenizer_unit_assert.svh =====
// Assertion macros for the CSV record tokenizer.
// Used by the top level; no other dependencies.
`ifndef CSV_RECORD_TOKENIZER_UNIT_ASSERT_SVH
`define CSV_RECORD_TOKENIZER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked out of reset.
`define CTOK_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("tokenizer check failed");
// Next-cycle implication, checked out of reset.
`define CTOK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("tokenizer check failed");
`else
`define CTOK_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CTOK_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/ctok_pkg.sv =====
// Shared types and byte constants for the CSV record tokenizer.
// No dependencies; used by every module of the block.
package ctok_pkg;

  // Byte constants of the format.
  localparam logic [7:0] BYTE_QUOTE = 8'h22;
  localparam logic [7:0] BYTE_COMMA = 8'h2C;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] BOM_0      = 8'hEF;
  localparam logic [7:0] BOM_1      = 8'hBB;
  localparam logic [7:0] BOM_2      = 8'hBF;

  // Most results one input item can cause.
  localparam int unsigned MAX_RES = 3;
  localparam int unsigned CNT_W   = $clog2(MAX_RES + 1);

  // Quote tracking: outside quotes, inside quotes, quote seen inside quotes.
  typedef enum logic [2:0] {
    QM_UNQUOTED = 3'b001,
    QM_QUOTED   = 3'b010,
    QM_PENDING  = 3'b100
  } quote_mode_e;

  // Byte-order mark detection at file start.
  typedef enum logic [3:0] {
    BOM_IDLE = 4'b0001,
    BOM_EF   = 4'b0010,
    BOM_EFBB = 4'b0100,
    BOM_DONE = 4'b1000
  } bom_stage_e;

  // Tokenizer state carried from byte to byte.
  typedef struct packed {
    quote_mode_e qm;
    logic        rec_start;
    logic        after_cr;
  } tok_state_t;

  localparam tok_state_t TOK_RESET = '{qm: QM_UNQUOTED, rec_start: 1'b1, after_cr: 1'b0};

  // One result item without its last-of-run mark.
  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic       field_end;
    logic       record_end;
  } result_t;

endpackage

// ===== sv/csv_record_tokenizer_unit.sv =====
// CSV record tokenizer top level: mark stripping, byte steps and output buffer.
// Depends on ctok_pkg, ctok_step, ctok_res_q and the assertion header.
//
// Usage: the input channel carries one item per handshake: kind_i = 0 with a
// data byte in byte_value_i, or kind_i = 1 for end of input. The output
// channel carries result items: a content byte (data_valid_o) and/or field and
// record end marks; last_of_run_o flags the final result of an input item.
// Results of an accepted item are offered from the next cycle on. An item
// causing at most one result does not hold the input, so one byte per cycle
// is sustained while the receiver is ready. An item causing several results
// (only when a partial byte-order mark is replayed, up to three) holds the
// input while the output buffer drains one result per cycle. If the receiver
// stalls, results wait in the buffer; a further item is taken only in the
// cycle the last buffered result leaves. Reset empties the buffer and returns
// the tokenizer to file start; an end-of-input item also returns it there.
`include "csv_record_tokenizer_unit_assert.svh"

module csv_record_tokenizer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       kind_i,
  input  logic [7:0] byte_value_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       data_valid_o,
  output logic [7:0] data_byte_o,
  output logic       field_end_o,
  output logic       record_end_o,
  output logic       last_of_run_o
);

  localparam int unsigned NCAND = ctok_pkg::MAX_RES + 1;

  ctok_pkg::tok_state_t tok_q, tok_d;
  ctok_pkg::bom_stage_e bom_q, bom_d;

  logic                                       in_fire;
  logic [ctok_pkg::MAX_RES-1:0]               slot_en;
  logic [ctok_pkg::MAX_RES-1:0][7:0]          seq;
  ctok_pkg::tok_state_t [ctok_pkg::MAX_RES:0] st_chain;
  ctok_pkg::tok_state_t [ctok_pkg::MAX_RES-1:0] step_st;
  logic [ctok_pkg::MAX_RES-1:0]               step_emit;
  ctok_pkg::result_t [ctok_pkg::MAX_RES-1:0]  step_res;
  ctok_pkg::result_t [NCAND-1:0]              cand;
  logic [NCAND-1:0]                           cand_en;
  ctok_pkg::result_t [ctok_pkg::MAX_RES-1:0]  grp;
  logic [ctok_pkg::CNT_W-1:0]                 grp_cnt;
  ctok_pkg::result_t                          head;

  assign in_fire = in_valid_i && in_ready_o;

  // Byte-order mark handling picks the bytes to run through the steps.
  always_comb begin
    bom_d   = bom_q;
    slot_en = '0;
    seq     = {ctok_pkg::MAX_RES{byte_value_i}};
    if (!kind_i) begin
      case (bom_q)
        ctok_pkg::BOM_IDLE: begin
          if (byte_value_i == ctok_pkg::BOM_0) begin
            bom_d = ctok_pkg::BOM_EF;
          end else begin
            bom_d   = ctok_pkg::BOM_DONE;
            slot_en = 3'b001;
          end
        end
        ctok_pkg::BOM_EF: begin
          if (byte_value_i == ctok_pkg::BOM_1) begin
            bom_d = ctok_pkg::BOM_EFBB;
          end else begin
            bom_d   = ctok_pkg::BOM_DONE;
            seq[0]  = ctok_pkg::BOM_0;
            slot_en = 3'b011;
          end
        end
        ctok_pkg::BOM_EFBB: begin
          bom_d = ctok_pkg::BOM_DONE;
          if (byte_value_i != ctok_pkg::BOM_2) begin
            seq[0]  = ctok_pkg::BOM_0;
            seq[1]  = ctok_pkg::BOM_1;
            slot_en = 3'b111;
          end
        end
        default: slot_en = 3'b001;
      endcase
    end else begin
      // End of input replays a held partial mark, then starts a new file.
      bom_d = ctok_pkg::BOM_IDLE;
      case (bom_q)
        ctok_pkg::BOM_EF: begin
          seq[0]  = ctok_pkg::BOM_0;
          slot_en = 3'b001;
        end
        ctok_pkg::BOM_EFBB: begin
          seq[0]  = ctok_pkg::BOM_0;
          seq[1]  = ctok_pkg::BOM_1;
          slot_en = 3'b011;
        end
        default: slot_en = '0;
      endcase
    end
  end

  // Chain of byte steps; a disabled slot passes the state through.
  assign st_chain[0] = tok_q;

  for (genvar g = 0; g < ctok_pkg::MAX_RES; g++) begin : g_step
    ctok_step u_step (
      .st_i   (st_chain[g]),
      .byte_i (seq[g]),
      .st_o   (step_st[g]),
      .emit_o (step_emit[g]),
      .res_o  (step_res[g])
    );
    assign st_chain[g+1] = slot_en[g] ? step_st[g] : st_chain[g];
    assign cand[g]       = step_res[g];
    assign cand_en[g]    = slot_en[g] && step_emit[g];
  end

  // End of input closes a record that has begun.
  assign cand[NCAND-1]    = '{data_valid: 1'b0, data_byte: 8'h00,
                              field_end: 1'b1, record_end: 1'b1};
  assign cand_en[NCAND-1] = kind_i && !st_chain[ctok_pkg::MAX_RES].rec_start;

  // Pack the emitted results in order.
  always_comb begin
    grp     = '0;
    grp_cnt = '0;
    for (int i = 0; i < NCAND; i++) begin
      if (cand_en[i]) begin
        grp[grp_cnt[1:0]] = cand[i];
        grp_cnt           = grp_cnt + ctok_pkg::CNT_W'(1);
      end
    end
  end

  assign tok_d = kind_i ? ctok_pkg::TOK_RESET : st_chain[ctok_pkg::MAX_RES];

  // Tokenizer state advances on every accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= ctok_pkg::TOK_RESET;
      bom_q <= ctok_pkg::BOM_IDLE;
    end else if (in_fire) begin
      tok_q <= tok_d;
      bom_q <= bom_d;
    end
  end

  // Output buffer.
  ctok_res_q u_res_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_fire),
    .push_cnt_i (grp_cnt),
    .push_res_i (grp),
    .pop_i      (out_ready_i),
    .can_push_o (in_ready_o),
    .valid_o    (out_valid_o),
    .last_o     (last_of_run_o),
    .head_o     (head)
  );

  assign data_valid_o = head.data_valid;
  assign data_byte_o  = head.data_byte;
  assign field_end_o  = head.field_end;
  assign record_end_o = head.record_end;

  // Checks on the block's own logic.
  `CTOK_ASSERT_IMPL(a_group_blocks_input, clk_i, rst_ni,
                    out_valid_o && !last_of_run_o, !in_ready_o)
  `CTOK_ASSERT_IMPL(a_mark_has_zero_byte, clk_i, rst_ni,
                    out_valid_o && !data_valid_o, data_byte_o == 8'h00)
  `CTOK_ASSERT_IMPL(a_record_end_ends_field, clk_i, rst_ni,
                    out_valid_o && record_end_o, field_end_o && !data_valid_o)
  `CTOK_ASSERT_NEXT(a_eoi_restarts, clk_i, rst_ni,
                    in_fire && kind_i,
                    bom_q == ctok_pkg::BOM_IDLE && tok_q == ctok_pkg::TOK_RESET)

endmodule

// ===== sv/ctok_step.sv =====
// Handles one byte of the stream: quoting, separators and line ends.
// Depends on ctok_pkg. Purely combinational; chained by the top level.
module ctok_step (
  input  ctok_pkg::tok_state_t st_i,
  input  logic [7:0]           byte_i,
  output ctok_pkg::tok_state_t st_o,
  output logic                 emit_o,
  output ctok_pkg::result_t    res_o
);

  logic skip;
  logic plain;

  always_comb begin
    st_o          = st_i;
    st_o.after_cr = 1'b0;
    emit_o        = 1'b0;
    res_o         = '0;
    plain         = 1'b0;
    // An LF right after an unquoted CR line end is swallowed.
    skip = st_i.after_cr && (byte_i == ctok_pkg::BYTE_LF);

    if (!skip) begin
      case (st_i.qm)
        ctok_pkg::QM_QUOTED: begin
          if (byte_i == ctok_pkg::BYTE_QUOTE) begin
            st_o.qm = ctok_pkg::QM_PENDING;
          end else begin
            emit_o           = 1'b1;
            res_o.data_valid = 1'b1;
            res_o.data_byte  = byte_i;
          end
          st_o.rec_start = 1'b0;
        end
        ctok_pkg::QM_PENDING: begin
          // A doubled quote is one literal quote; anything else closes quotes.
          if (byte_i == ctok_pkg::BYTE_QUOTE) begin
            emit_o           = 1'b1;
            res_o.data_valid = 1'b1;
            res_o.data_byte  = ctok_pkg::BYTE_QUOTE;
            st_o.qm          = ctok_pkg::QM_QUOTED;
          end else begin
            plain = 1'b1;
          end
        end
        default: plain = 1'b1;
      endcase
    end

    // Unquoted handling.
    if (plain) begin
      st_o.qm = ctok_pkg::QM_UNQUOTED;
      if (byte_i == ctok_pkg::BYTE_QUOTE) begin
        st_o.qm        = ctok_pkg::QM_QUOTED;
        st_o.rec_start = 1'b0;
      end else if (byte_i == ctok_pkg::BYTE_COMMA) begin
        emit_o          = 1'b1;
        res_o.field_end = 1'b1;
        st_o.rec_start  = 1'b0;
      end else if (byte_i == ctok_pkg::BYTE_CR || byte_i == ctok_pkg::BYTE_LF) begin
        // A blank line gives no record end.
        if (!st_i.rec_start) begin
          emit_o           = 1'b1;
          res_o.field_end  = 1'b1;
          res_o.record_end = 1'b1;
        end
        st_o.rec_start = 1'b1;
        st_o.after_cr  = (byte_i == ctok_pkg::BYTE_CR);
      end else begin
        emit_o           = 1'b1;
        res_o.data_valid = 1'b1;
        res_o.data_byte  = byte_i;
        st_o.rec_start   = 1'b0;
      end
    end
  end

endmodule

// ===== sv/ctok_res_q.sv =====
// Result buffer: holds the results of one item and hands them out one a cycle while popped.
// Depends on ctok_pkg.
module ctok_res_q (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push_i,
  input  logic [ctok_pkg::CNT_W-1:0]            push_cnt_i,
  input  ctok_pkg::result_t [ctok_pkg::MAX_RES-1:0] push_res_i,
  input  logic                                  pop_i,
  output logic                                  can_push_o,
  output logic                                  valid_o,
  output logic                                  last_o,
  output ctok_pkg::result_t                     head_o
);

  ctok_pkg::result_t [ctok_pkg::MAX_RES-1:0] res_q;
  logic [ctok_pkg::CNT_W-1:0]                cnt_q, cnt_d;
  logic [ctok_pkg::CNT_W-1:0]                rd_q, rd_d;

  // A new group may enter once the buffer is empty or its last entry leaves.
  assign valid_o    = (cnt_q != '0);
  assign last_o     = (cnt_q == ctok_pkg::CNT_W'(1));
  assign can_push_o = !valid_o || (last_o && pop_i);
  assign head_o     = res_q[rd_q];

  // Read pointer and fill count.
  always_comb begin
    cnt_d = cnt_q;
    rd_d  = rd_q;
    if (push_i) begin
      cnt_d = push_cnt_i;
      rd_d  = '0;
    end else if (pop_i && valid_o) begin
      cnt_d = cnt_q - ctok_pkg::CNT_W'(1);
      rd_d  = rd_q + ctok_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
    end
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= push_res_i;
    end
  end

endmodule
